/* rtl/ffa_pkg.sv */
package ffa_pkg;

  localparam int ARENA_UNITS = 4096;
  localparam int UNIT_BYTES  = 8;
  localparam int ADDR_W      = 12;
  localparam int SIZE_W      = 13;
  localparam int BYTES_W     = 15;
  localparam int UNIT_SHIFT  = $clog2(UNIT_BYTES);

  localparam logic [SIZE_W-1:0] ARENA_SIZE = SIZE_W'(ARENA_UNITS);

  typedef enum logic [0:0] {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [0:0] {
    STAT_OK  = 1'b0,
    STAT_OOM = 1'b1
  } status_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_A_FIRST,
    ST_A_EVAL,
    ST_A_SPLIT,
    ST_F_WALK,
    ST_F_R1,
    ST_F_R2,
    ST_F_R3,
    ST_F_W2,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } link_req_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [SIZE_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } size_req_t;

  // saturating add of two block sizes
  function automatic logic [SIZE_W-1:0] sat_units(logic [SIZE_W-1:0] a,
                                                  logic [SIZE_W-1:0] b);
    logic [SIZE_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > {1'b0, ARENA_SIZE}) ? ARENA_SIZE : s[SIZE_W-1:0];
  endfunction

endpackage

/* rtl/first_fit_free_list_allocator.sv */
// Channel  Handshake                  tdata                           tuser
// in       in_tvalid / in_tready      [14:0] size_bytes [26:15] addr  op (0 alloc, 1 free)
// out      out_tvalid / out_tready    [11:0] payload_addr             status (1 = out of mem)
//
// After reset a clearing pass writes all 4096 headers; no input is taken meanwhile.
// Allocate: walks the free blocks first fit from the head; a split writes the remainder
// header, then the front size and previous link; an empty list answers out of memory.
// Free: walks to the insert point, reads the sizes of the block and its neighbours, then
// links it in and merges with adjacent free blocks; into an empty list it is the sole block.
// The walk runs one header per cycle through the link (and for allocate, size) read ports.
// The output register holds a result under back pressure; the next item is taken
// once the previous result is loaded into it.
module first_fit_free_list_allocator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // size_bytes[14:0], block_addr[26:15], zeros
  input  logic        in_tuser,   // op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // payload_addr[11:0], zeros
  output logic        out_tuser   // status
);

  ffa_pkg::link_req_t                link_req;
  ffa_pkg::size_req_t                size_req;
  logic [ffa_pkg::ADDR_W-1:0]        link_rd;
  logic [ffa_pkg::SIZE_W-1:0]        size_rd;

  ffa_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .link_req   (link_req),
    .link_rd    (link_rd),
    .size_req   (size_req),
    .size_rd    (size_rd)
  );

  ffa_ram #(
    .DATA_W (ffa_pkg::ADDR_W),
    .ADDR_W (ffa_pkg::ADDR_W)
  ) u_link_ram (
    .clk   (clk),
    .we    (link_req.we),
    .waddr (link_req.waddr),
    .wdata (link_req.wdata),
    .raddr (link_req.raddr),
    .rdata (link_rd)
  );

  ffa_ram #(
    .DATA_W (ffa_pkg::SIZE_W),
    .ADDR_W (ffa_pkg::ADDR_W)
  ) u_size_ram (
    .clk   (clk),
    .we    (size_req.we),
    .waddr (size_req.waddr),
    .wdata (size_req.wdata),
    .raddr (size_req.raddr),
    .rdata (size_rd)
  );

endmodule

/* rtl/ffa_ram.sv */
module ffa_ram #(
  parameter int DATA_W = 12,
  parameter int ADDR_W = 12
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* rtl/ffa_ctrl.sv */
module ffa_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [31:0]               in_tdata,
  input  logic                      in_tuser,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [15:0]               out_tdata,
  output logic                      out_tuser,
  output ffa_pkg::link_req_t        link_req,
  input  logic [ffa_pkg::ADDR_W-1:0] link_rd,
  output ffa_pkg::size_req_t        size_req,
  input  logic [ffa_pkg::SIZE_W-1:0] size_rd
);

  localparam int AW = ffa_pkg::ADDR_W;
  localparam int SW = ffa_pkg::SIZE_W;
  localparam logic [AW-1:0] LAST_UNIT = AW'(ffa_pkg::ARENA_UNITS - 1);

  ffa_pkg::state_t state_r, state_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic          empty_r, empty_nxt;
  logic [AW-1:0] blk_r, blk_nxt;
  logic [SW-1:0] need_r, need_nxt;
  logic [AW-1:0] prev_r, prev_nxt;
  logic [AW-1:0] cur_r, cur_nxt;
  logic [AW-1:0] nx_r, nx_nxt;
  logic [AW-1:0] rest_r, rest_nxt;
  logic [SW-1:0] steps_r, steps_nxt;
  logic [AW-1:0] lnx_r, lnx_nxt;
  logic [AW-1:0] lblk_r, lblk_nxt;
  logic [SW-1:0] sblk_r, sblk_nxt;
  logic [SW-1:0] snx_r, snx_nxt;
  logic [SW-1:0] scur_r, scur_nxt;
  logic          res_st_r, res_st_nxt;
  logic [AW-1:0] res_addr_r, res_addr_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_st_r, out_st_nxt;
  logic [AW-1:0] out_addr_r, out_addr_nxt;

  logic [ffa_pkg::BYTES_W-1:0] in_bytes;
  logic [AW-1:0]               in_addr;
  logic [ffa_pkg::BYTES_W:0]   bytes_up;
  logic [SW-1:0]               need_calc;
  logic                        walk_open;
  logic [SW:0]                 cur_end;
  logic [SW-1:0]               have_left;
  logic                        placed;
  logic [SW:0]                 blk_end;
  logic [SW:0]                 cur_tail;

  assign in_bytes  = in_tdata[14:0];
  assign in_addr   = in_tdata[26:15];
  assign bytes_up  = {1'b0, in_bytes} + (ffa_pkg::BYTES_W+1)'(ffa_pkg::UNIT_BYTES - 1);
  assign need_calc = SW'(bytes_up >> ffa_pkg::UNIT_SHIFT) + SW'(1);
  assign walk_open = (steps_r != ffa_pkg::ARENA_SIZE);
  assign cur_end   = {2'b00, cur_r} + {1'b0, need_r};
  assign have_left = size_rd - need_r;
  assign placed    = ((blk_r > cur_r) && (blk_r < link_rd)) ||
                     ((cur_r >= link_rd) && ((blk_r > cur_r) || (blk_r < link_rd)));
  assign blk_end   = {2'b00, blk_r} + {1'b0, sblk_r};
  assign cur_tail  = {2'b00, cur_r} + {1'b0, scur_r};

  assign in_tready  = (state_r == ffa_pkg::ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_st_r;
  assign out_tdata  = {{(16-AW){1'b0}}, out_addr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ffa_pkg::ST_CLEAR;
      clr_r       <= '0;
      head_r      <= '0;
      empty_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      head_r      <= head_nxt;
      empty_r     <= empty_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    blk_r      <= blk_nxt;
    need_r     <= need_nxt;
    prev_r     <= prev_nxt;
    cur_r      <= cur_nxt;
    nx_r       <= nx_nxt;
    rest_r     <= rest_nxt;
    steps_r    <= steps_nxt;
    lnx_r      <= lnx_nxt;
    lblk_r     <= lblk_nxt;
    sblk_r     <= sblk_nxt;
    snx_r      <= snx_nxt;
    scur_r     <= scur_nxt;
    res_st_r   <= res_st_nxt;
    res_addr_r <= res_addr_nxt;
    out_st_r   <= out_st_nxt;
    out_addr_r <= out_addr_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    head_nxt      = head_r;
    empty_nxt     = empty_r;
    blk_nxt       = blk_r;
    need_nxt      = need_r;
    prev_nxt      = prev_r;
    cur_nxt       = cur_r;
    nx_nxt        = nx_r;
    rest_nxt      = rest_r;
    steps_nxt     = steps_r;
    lnx_nxt       = lnx_r;
    lblk_nxt      = lblk_r;
    sblk_nxt      = sblk_r;
    snx_nxt       = snx_r;
    scur_nxt      = scur_r;
    res_st_nxt    = res_st_r;
    res_addr_nxt  = res_addr_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_st_nxt    = out_st_r;
    out_addr_nxt  = out_addr_r;
    link_req      = '0;
    size_req      = '0;

    unique case (state_r)
      ffa_pkg::ST_CLEAR: begin
        link_req.we    = 1'b1;
        link_req.waddr = clr_r;
        size_req.we    = 1'b1;
        size_req.waddr = clr_r;
        size_req.wdata = (clr_r == '0) ? ffa_pkg::ARENA_SIZE : '0;
        clr_nxt        = clr_r + AW'(1);
        if (clr_r == LAST_UNIT) begin
          state_nxt = ffa_pkg::ST_IDLE;
        end
      end

      ffa_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          res_st_nxt   = ffa_pkg::STAT_OK;
          res_addr_nxt = '0;
          need_nxt     = need_calc;
          blk_nxt      = in_addr - AW'(1);
          steps_nxt    = '0;
          if (in_tuser == ffa_pkg::OP_ALLOC) begin
            if (empty_r) begin
              res_st_nxt = ffa_pkg::STAT_OOM;
              state_nxt  = ffa_pkg::ST_RESP;
            end else begin
              link_req.raddr = head_r;
              prev_nxt       = head_r;
              state_nxt      = ffa_pkg::ST_A_FIRST;
            end
          end else begin
            if (in_addr == '0) begin
              state_nxt = ffa_pkg::ST_RESP;
            end else if (empty_r) begin
              // sole list element
              link_req.we    = 1'b1;
              link_req.waddr = in_addr - AW'(1);
              link_req.wdata = in_addr - AW'(1);
              head_nxt       = in_addr - AW'(1);
              empty_nxt      = 1'b0;
              state_nxt      = ffa_pkg::ST_RESP;
            end else begin
              link_req.raddr = head_r;
              cur_nxt        = head_r;
              state_nxt      = ffa_pkg::ST_F_WALK;
            end
          end
        end
      end

      ffa_pkg::ST_A_FIRST: begin
        cur_nxt        = link_rd;
        link_req.raddr = link_rd;
        size_req.raddr = link_rd;
        state_nxt      = ffa_pkg::ST_A_EVAL;
      end

      ffa_pkg::ST_A_EVAL: begin
        if (size_rd == need_r) begin
          if (prev_r == cur_r) begin
            empty_nxt = 1'b1;
          end else begin
            link_req.we    = 1'b1;
            link_req.waddr = prev_r;
            link_req.wdata = link_rd;
            head_nxt       = prev_r;
          end
          res_addr_nxt = cur_r + AW'(1);
          state_nxt    = ffa_pkg::ST_RESP;
        end else if ((size_rd > need_r) && (cur_end < (SW+1)'(ffa_pkg::ARENA_UNITS))) begin
          // split: remainder header first, then front size and the prev link
          rest_nxt       = cur_end[AW-1:0];
          link_req.we    = 1'b1;
          link_req.waddr = cur_end[AW-1:0];
          link_req.wdata = link_rd;
          size_req.we    = 1'b1;
          size_req.waddr = cur_end[AW-1:0];
          size_req.wdata = have_left;
          prev_nxt       = (prev_r == cur_r) ? cur_end[AW-1:0] : prev_r;
          head_nxt       = (prev_r == cur_r) ? cur_end[AW-1:0] : prev_r;
          res_addr_nxt   = cur_r + AW'(1);
          state_nxt      = ffa_pkg::ST_A_SPLIT;
        end else if ((cur_r == head_r) || !walk_open) begin
          res_st_nxt = ffa_pkg::STAT_OOM;
          state_nxt  = ffa_pkg::ST_RESP;
        end else begin
          prev_nxt       = cur_r;
          cur_nxt        = link_rd;
          link_req.raddr = link_rd;
          size_req.raddr = link_rd;
          steps_nxt      = steps_r + SW'(1);
        end
      end

      ffa_pkg::ST_A_SPLIT: begin
        size_req.we    = 1'b1;
        size_req.waddr = cur_r;
        size_req.wdata = need_r;
        link_req.we    = 1'b1;
        link_req.waddr = prev_r;
        link_req.wdata = rest_r;
        state_nxt      = ffa_pkg::ST_RESP;
      end

      ffa_pkg::ST_F_WALK: begin
        if (placed) begin
          nx_nxt         = link_rd;
          size_req.raddr = blk_r;
          link_req.raddr = link_rd;
          state_nxt      = ffa_pkg::ST_F_R1;
        end else if (!walk_open) begin
          state_nxt = ffa_pkg::ST_RESP;
        end else begin
          cur_nxt        = link_rd;
          link_req.raddr = link_rd;
          steps_nxt      = steps_r + SW'(1);
        end
      end

      ffa_pkg::ST_F_R1: begin
        sblk_nxt       = size_rd;
        lnx_nxt        = link_rd;
        size_req.raddr = nx_r;
        state_nxt      = ffa_pkg::ST_F_R2;
      end

      ffa_pkg::ST_F_R2: begin
        snx_nxt        = size_rd;
        size_req.raddr = cur_r;
        state_nxt      = ffa_pkg::ST_F_R3;
      end

      ffa_pkg::ST_F_R3: begin
        scur_nxt = size_rd;
        if (blk_end == {2'b00, nx_r}) begin
          // merge with the following block
          size_req.we    = 1'b1;
          size_req.waddr = blk_r;
          size_req.wdata = ffa_pkg::sat_units(sblk_r, snx_r);
          sblk_nxt       = ffa_pkg::sat_units(sblk_r, snx_r);
          link_req.we    = 1'b1;
          link_req.waddr = blk_r;
          if (cur_r == nx_r) begin
            link_req.wdata = blk_r;
            head_nxt       = blk_r;
            state_nxt      = ffa_pkg::ST_RESP;
          end else begin
            link_req.wdata = lnx_r;
            lblk_nxt       = lnx_r;
            state_nxt      = ffa_pkg::ST_F_W2;
          end
        end else begin
          link_req.we    = 1'b1;
          link_req.waddr = blk_r;
          link_req.wdata = nx_r;
          lblk_nxt       = nx_r;
          state_nxt      = ffa_pkg::ST_F_W2;
        end
      end

      ffa_pkg::ST_F_W2: begin
        link_req.we    = 1'b1;
        link_req.waddr = cur_r;
        if (cur_tail == {2'b00, blk_r}) begin
          size_req.we    = 1'b1;
          size_req.waddr = cur_r;
          size_req.wdata = ffa_pkg::sat_units(scur_r, sblk_r);
          link_req.wdata = lblk_r;
        end else begin
          link_req.wdata = blk_r;
        end
        head_nxt  = cur_r;
        state_nxt = ffa_pkg::ST_RESP;
      end

      ffa_pkg::ST_RESP: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_st_nxt    = res_st_r;
          out_addr_nxt  = res_addr_r;
          state_nxt     = ffa_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = ffa_pkg::ST_IDLE;
      end
    endcase
  end

  a_clear_no_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ffa_pkg::ST_CLEAR) |-> !out_valid_r)
    else $error("result word during clearing pass");

  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ffa_pkg::ST_IDLE) |-> (!size_req.we && (!link_req.we || in_tvalid)))
    else $error("store written while idle");

  a_oom_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_st_r == ffa_pkg::STAT_OOM)) |-> (out_addr_r == '0))
    else $error("failed allocate carries an address");

  a_resp_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ffa_pkg::ST_RESP) && (!out_valid_r || out_tready))
      |=> (state_r == ffa_pkg::ST_IDLE) && out_valid_r)
    else $error("result not loaded into output register");

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;

  localparam int IDLE_LIMIT = 60000;

  typedef struct packed {
    ffa_pkg::status_t           status;
    logic [ffa_pkg::ADDR_W-1:0] addr;
  } grant_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic        out_tuser;

  // shadow copy of the allocator's headers
  int unsigned free_link [ffa_pkg::ARENA_UNITS];
  int unsigned free_size [ffa_pkg::ARENA_UNITS];
  int unsigned free_head;
  bit          arena_empty;

  grant_t      pending_grants[$];
  int unsigned live_blocks[$];
  int          error_count;
  bit          sender_busy_mode;
  bit          rx_hold_req;
  bit          rx_no_gaps;
  int          quiet_cycles;

  first_fit_free_list_allocator i_dut (.*);

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int unsigned sat_add(int unsigned a, int unsigned b);
    return (a + b > ffa_pkg::ARENA_UNITS) ? ffa_pkg::ARENA_UNITS : a + b;
  endfunction

  function automatic bit carve_block(int unsigned bytes, output int unsigned where);
    int unsigned need, prev, cur, have, rest;
    need = (bytes + ffa_pkg::UNIT_BYTES - 1) / ffa_pkg::UNIT_BYTES + 1;
    where = 0;
    if (arena_empty) return 1'b0;
    prev = free_head;
    cur  = free_link[prev];
    for (int unsigned steps = 0; steps <= ffa_pkg::ARENA_UNITS; steps++) begin
      have = free_size[cur];
      if (have == need) begin
        if (prev == cur) begin
          arena_empty = 1'b1;
        end else begin
          free_link[prev] = free_link[cur];
          free_head = prev;
        end
        where = cur + 1;
        return 1'b1;
      end
      if (have > need && cur + need < ffa_pkg::ARENA_UNITS) begin
        rest = cur + need;
        free_link[rest] = free_link[cur];
        free_size[rest] = have - need;
        free_size[cur] = need;
        if (prev == cur) prev = rest;
        free_link[prev] = rest;
        free_head = prev;
        where = cur + 1;
        return 1'b1;
      end
      if (cur == free_head) break;
      prev = cur;
      cur = free_link[cur];
    end
    return 1'b0;
  endfunction

  function automatic void return_block(int unsigned payload);
    int unsigned blk, cur, nx;
    bit placed;
    placed = 1'b0;
    if (payload == 0 || payload - 1 >= ffa_pkg::ARENA_UNITS) return;
    blk = payload - 1;
    if (arena_empty) begin
      free_head = blk;
      free_link[blk] = blk;
      arena_empty = 1'b0;
      return;
    end
    cur = free_head;
    for (int unsigned steps = 0; steps <= ffa_pkg::ARENA_UNITS; steps++) begin
      nx = free_link[cur];
      if (blk > cur && blk < nx) begin
        placed = 1'b1;
        break;
      end
      if (cur >= nx && (blk > cur || blk < nx)) begin
        placed = 1'b1;
        break;
      end
      cur = nx;
    end
    if (!placed) return;
    nx = free_link[cur];
    if (blk + free_size[blk] == nx) begin
      free_size[blk] = sat_add(free_size[blk], free_size[nx]);
      if (cur == nx) begin
        free_link[blk] = blk;
        free_head = blk;
        return;
      end
      free_link[blk] = free_link[nx];
    end else begin
      free_link[blk] = nx;
    end
    if (cur + free_size[cur] == blk) begin
      free_size[cur] = sat_add(free_size[cur], free_size[blk]);
      free_link[cur] = free_link[blk];
    end else begin
      free_link[cur] = blk;
    end
    free_head = cur;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d, want %0d at %0t", what, got, want, $time);
    error_count++;
  endtask

  // drive one word, wait for it to be taken, then predict its grant
  task automatic send_word(ffa_pkg::op_t op, int unsigned bytes, int unsigned addr);
    grant_t g;
    int unsigned where;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {5'b0, addr[ffa_pkg::ADDR_W-1:0], bytes[ffa_pkg::BYTES_W-1:0]};
    do @(posedge clk); while (!in_tready);
    g = '0;
    if (op == ffa_pkg::OP_ALLOC) begin
      if (carve_block(bytes, where)) begin
        g.addr = where[ffa_pkg::ADDR_W-1:0];
        live_blocks.push_back(where & 12'hFFF);
      end else begin
        g.status = ffa_pkg::STAT_OOM;
      end
    end else begin
      return_block(addr & 12'hFFF);
    end
    pending_grants.push_back(g);
    if (!sender_busy_mode) idle_sender(gap_len());
  endtask

  task automatic idle_sender(int n);
    if (n > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    idle_sender(1);
    while (pending_grants.size() != 0) @(posedge clk);
  endtask

  task automatic free_random_live();
    int idx;
    idx = $urandom_range(0, live_blocks.size() - 1);
    send_word(ffa_pkg::OP_FREE, $urandom, live_blocks[idx]);
    live_blocks.delete(idx);
  endtask

  task automatic test_directed();
    send_word(ffa_pkg::OP_ALLOC, 32767, 0);   // larger than the arena
    send_word(ffa_pkg::OP_ALLOC, 0, 0);       // header only
    send_word(ffa_pkg::OP_ALLOC, 1, 0);
    send_word(ffa_pkg::OP_ALLOC, 8, 0);
    send_word(ffa_pkg::OP_ALLOC, 9, 0);
    send_word(ffa_pkg::OP_FREE, 0, 0);        // address zero is dropped
    send_word(ffa_pkg::OP_FREE, 0, 2);        // linked in beside the only free block, no merge
    send_word(ffa_pkg::OP_FREE, 0, 1);        // merges forward with the block freed before
    send_word(ffa_pkg::OP_FREE, 0, 4);
    send_word(ffa_pkg::OP_FREE, 0, 3);
    live_blocks.delete();
    send_word(ffa_pkg::OP_ALLOC, 32760, 0);   // the whole arena, more than is free while payload 6 is held
    send_word(ffa_pkg::OP_ALLOC, 0, 0);       // header only
    send_word(ffa_pkg::OP_FREE, 32767, 1);    // payload 1 again, already free
    send_word(ffa_pkg::OP_ALLOC, 32752, 0);   // one unit short of the whole arena
    send_word(ffa_pkg::OP_ALLOC, 0, 0);       // header only
    send_word(ffa_pkg::OP_FREE, 0, 4095);
    send_word(ffa_pkg::OP_FREE, 0, 1);
    live_blocks.delete();
    wait_drained();
  endtask

  task automatic test_random(int n);
    int r;
    for (int k = 0; k < n; k++) begin
      if (k % 200 == 100) sender_busy_mode = 1'b1;
      if (k % 200 == 140) sender_busy_mode = 1'b0;
      r = $urandom_range(0, 99);
      if (live_blocks.size() == 0 || r < 52) begin
        if (r % 20 == 0) send_word(ffa_pkg::OP_ALLOC, $urandom_range(0, 32767), 0);
        else send_word(ffa_pkg::OP_ALLOC, $urandom_range(0, 160), 0);
      end else if (r < 94) begin
        free_random_live();
      end else begin
        send_word(ffa_pkg::OP_FREE, $urandom_range(0, 32767), $urandom_range(0, 4095));
      end
    end
    sender_busy_mode = 1'b0;
    wait_drained();
  endtask

  task automatic test_backpressure();
    rx_hold_req = 1'b1;
    sender_busy_mode = 1'b1;
    for (int k = 0; k < 12; k++) begin
      if (k % 2 == 0 || live_blocks.size() == 0)
        send_word(ffa_pkg::OP_ALLOC, $urandom_range(0, 64), 0);
      else free_random_live();
    end
    sender_busy_mode = 1'b0;
    wait_drained();
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int hold;
    int gap;
    hold = 0;
    gap = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        hold = 300;
      end
      if (hold > 0) begin
        hold--;
        out_tready <= 1'b0;
      end else if (gap > 0) begin
        gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (!rx_no_gaps) gap = gap_len();
      end
    end
  end

  always @(posedge clk) begin
    grant_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_grants.size() == 0) begin
        report_mismatch("unexpected word", int'(out_tdata[ffa_pkg::ADDR_W-1:0]), -1);
      end else begin
        want = pending_grants.pop_front();
        if (out_tuser !== want.status)
          report_mismatch("status", int'(out_tuser), int'(want.status));
        if (out_tdata !== {4'b0, want.addr})
          report_mismatch("payload_addr", int'(out_tdata), int'(want.addr));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles > IDLE_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    free_link = '{default: 0};
    free_size = '{default: 0};
    free_size[0] = ffa_pkg::ARENA_UNITS;
    free_head = 0;
    arena_empty = 1'b0;
    error_count = 0;
    quiet_cycles = 0;
    sender_busy_mode = 1'b0;
    rx_hold_req = 1'b0;
    rx_no_gaps = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_backpressure();
    test_random(500);
    rx_no_gaps = 1'b1;
    test_random(200);
    rx_no_gaps = 1'b0;
    test_random(320);
    repeat (40) @(posedge clk);
    if (error_count == 0 && pending_grants.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
